[hdl/pcdr_pkg.sv]
// ----------------------------------------------------------------------------
// pcdr_pkg
// Shared constants, command type and blend helper for the pixel compositor
// with dirty area tracking.
// ----------------------------------------------------------------------------
package pcdr_pkg;

    localparam int SCREEN_W    = 1024;
    localparam int SCREEN_H    = 1024;
    localparam int COORD_W     = 11;
    localparam int POS_W       = 12;
    localparam int ADDR_W      = 20;
    localparam int PIX_W       = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0]       THRESH_RESET = 8'd100;
    localparam logic [7:0]       ALPHA_CLEAR  = 8'h00;
    localparam logic [7:0]       ALPHA_OPAQUE = 8'hff;
    localparam logic [PIX_W-1:0] ALPHA_FORCE  = 32'hff00_0000;

    localparam logic       OP_DRAW  = 1'b0;
    localparam logic       OP_FLUSH = 1'b1;

    localparam logic [1:0] MODE_SOLID = 2'd0;
    localparam logic [1:0] MODE_COPY  = 2'd1;
    localparam logic [1:0] MODE_BLEND = 2'd2;
    localparam logic [1:0] MODE_GLYPH = 2'd3;

    // One classified beat travelling from front to back.
    typedef struct packed {
        logic               do_blend;
        logic               write_en;
        logic [ADDR_W-1:0]  pixel_addr;
        logic [PIX_W-1:0]   value;      // final value, or blend source
        logic [PIX_W-1:0]   dst;        // blend destination
        logic               area_valid;
        logic [COORD_W-1:0] area_left;
        logic [COORD_W-1:0] area_right;
        logic [COORD_W-1:0] area_top;
        logic [COORD_W-1:0] area_bottom;
    } t_cmd;

    // old + floor((new - old) * a / 256), modulo 256
    function automatic logic [7:0] mix_channel(input logic [7:0] a,
                                               input logic [7:0] nc,
                                               input logic [7:0] oc);
        logic signed [9:0]  d;
        logic signed [9:0]  as;
        logic signed [18:0] p;
        d  = $signed({2'b00, nc}) - $signed({2'b00, oc});
        as = $signed({2'b00, a});
        p  = d * as;
        return oc + p[15:8];
    endfunction

endpackage

[hdl/pixel_compositor_dirty_rect_core.sv]
// ----------------------------------------------------------------------------
// pixel_compositor_dirty_rect_core
// Framebuffer pixel write stage with ARGB blend and dirty area tracking.
// ----------------------------------------------------------------------------
// Throughput is one item per clock while full is low and results are popped:
// the front classifies a beat in the cycle it is pushed, a four-entry queue
// decouples it from the back, and the back blends (three 9x8 multiplies)
// into a single result register that refills on the same edge it is popped.
// Each item passes through the queue, then the result register. full rises
// once four commands wait in the queue; empty is low while a result is held.
// Draw beats: off-screen coordinates give an all-zero result and leave the
// dirty box alone; on-screen ones give write_en, the linear address
// (row * width + column) and the composited pixel, and grow the box.
// Blend mode keeps the old pixel at alpha 0, copies the source at alpha 255
// and otherwise mixes each channel and forces alpha to 0xff. Glyph mode
// draws the colour when the coverage byte exceeds the threshold.
// Flush beats report the box (end edges exclusive) when it is non-empty and
// then clear it. The glyph threshold resets to 100 and is written through
// the cfg channel, which is always ready; write it only while idle.
// ----------------------------------------------------------------------------
module pixel_compositor_dirty_rect_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [7:0]                           i_cfg_data,
    // item side
    input  logic                                 push,
    output logic                                 full,
    input  logic                                 i_op,
    input  logic signed [pcdr_pkg::POS_W-1:0]    i_pos_x,
    input  logic signed [pcdr_pkg::POS_W-1:0]    i_pos_y,
    input  logic [1:0]                           i_mode,
    input  logic [pcdr_pkg::PIX_W-1:0]           i_src_pixel,
    input  logic [pcdr_pkg::PIX_W-1:0]           i_draw_color,
    input  logic [pcdr_pkg::PIX_W-1:0]           i_dst_pixel,
    // result side
    output logic                                 empty,
    input  logic                                 pop,
    output logic                                 o_write_en,
    output logic [pcdr_pkg::ADDR_W-1:0]          o_pixel_addr,
    output logic [pcdr_pkg::PIX_W-1:0]           o_pixel_value,
    output logic                                 o_area_valid,
    output logic [pcdr_pkg::COORD_W-1:0]         o_area_left,
    output logic [pcdr_pkg::COORD_W-1:0]         o_area_right,
    output logic [pcdr_pkg::COORD_W-1:0]         o_area_top,
    output logic [pcdr_pkg::COORD_W-1:0]         o_area_bottom
);

    pcdr_pkg::t_cmd front_cmd;
    pcdr_pkg::t_cmd q_cmd;
    logic           accept;
    logic           q_rd;
    logic           q_empty;

    assign o_cfg_ready = 1'b1;
    assign accept      = push && !full;

    pcdr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (accept),
        .i_op         (i_op),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_mode       (i_mode),
        .i_src_pixel  (i_src_pixel),
        .i_draw_color (i_draw_color),
        .i_dst_pixel  (i_dst_pixel),
        .o_cmd        (front_cmd)
    );

    // classified beats wait here
    pcdr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (accept),
        .i_wdata (front_cmd),
        .o_full  (full),
        .i_rd    (q_rd),
        .o_rdata (q_cmd),
        .o_empty (q_empty)
    );

    pcdr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_cmd         (q_cmd),
        .o_q_rd        (q_rd),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_write_en    (o_write_en),
        .o_pixel_addr  (o_pixel_addr),
        .o_pixel_value (o_pixel_value),
        .o_area_valid  (o_area_valid),
        .o_area_left   (o_area_left),
        .o_area_right  (o_area_right),
        .o_area_top    (o_area_top),
        .o_area_bottom (o_area_bottom)
    );

endmodule

[hdl/pcdr_front.sv]
// ----------------------------------------------------------------------------
// pcdr_front
// Accepts items, clips coordinates, resolves simple modes, keeps the dirty
// box and the glyph threshold, and emits one command per item.
// ----------------------------------------------------------------------------
module pcdr_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    input  logic [7:0]                   i_cfg_data,
    input  logic                         i_accept,
    input  logic                         i_op,
    input  logic signed [pcdr_pkg::POS_W-1:0] i_pos_x,
    input  logic signed [pcdr_pkg::POS_W-1:0] i_pos_y,
    input  logic [1:0]                   i_mode,
    input  logic [pcdr_pkg::PIX_W-1:0]   i_src_pixel,
    input  logic [pcdr_pkg::PIX_W-1:0]   i_draw_color,
    input  logic [pcdr_pkg::PIX_W-1:0]   i_dst_pixel,
    output pcdr_pkg::t_cmd               o_cmd
);

    localparam logic [pcdr_pkg::COORD_W-1:0] W_C = pcdr_pkg::COORD_W'(pcdr_pkg::SCREEN_W);
    localparam logic [pcdr_pkg::COORD_W-1:0] H_C = pcdr_pkg::COORD_W'(pcdr_pkg::SCREEN_H);

    logic [7:0]                   r_thresh;
    logic [pcdr_pkg::COORD_W-1:0] r_left, r_right, r_top, r_bottom;
    logic [pcdr_pkg::COORD_W-1:0] n_left, n_right, n_top, n_bottom;

    logic                         on_screen;
    logic [pcdr_pkg::COORD_W-1:0] ux, uy, ux1, uy1, clip_r, clip_b;
    logic                         area_ok;
    logic [7:0]                   alpha;

    assign ux  = i_pos_x[pcdr_pkg::COORD_W-1:0];
    assign uy  = i_pos_y[pcdr_pkg::COORD_W-1:0];
    assign ux1 = ux + 1'b1;
    assign uy1 = uy + 1'b1;
    assign on_screen = !i_pos_x[pcdr_pkg::POS_W-1] && (ux < W_C) &&
                       !i_pos_y[pcdr_pkg::POS_W-1] && (uy < H_C);

    assign clip_r  = (r_right > W_C) ? W_C : r_right;
    assign clip_b  = (r_bottom > H_C) ? H_C : r_bottom;
    assign area_ok = (r_right != '0) && (clip_r > r_left) && (clip_b > r_top);
    assign alpha   = i_src_pixel[31:24];

    always_comb begin
        o_cmd = '0;
        if (i_op == pcdr_pkg::OP_FLUSH) begin
            if (area_ok) begin
                o_cmd.area_valid  = 1'b1;
                o_cmd.area_left   = r_left;
                o_cmd.area_right  = clip_r;
                o_cmd.area_top    = r_top;
                o_cmd.area_bottom = clip_b;
            end
        end else if (on_screen) begin
            o_cmd.write_en   = 1'b1;
            o_cmd.pixel_addr = pcdr_pkg::ADDR_W'(uy) * pcdr_pkg::ADDR_W'(pcdr_pkg::SCREEN_W)
                             + pcdr_pkg::ADDR_W'(ux);
            o_cmd.dst        = i_dst_pixel;
            unique case (i_mode)
                pcdr_pkg::MODE_SOLID: o_cmd.value = i_draw_color;
                pcdr_pkg::MODE_COPY:  o_cmd.value = i_src_pixel;
                pcdr_pkg::MODE_BLEND: begin
                    if (alpha == pcdr_pkg::ALPHA_CLEAR) begin
                        o_cmd.value = i_dst_pixel;
                    end else begin
                        o_cmd.value    = i_src_pixel;
                        o_cmd.do_blend = (alpha != pcdr_pkg::ALPHA_OPAQUE);
                    end
                end
                pcdr_pkg::MODE_GLYPH: begin
                    o_cmd.value = (i_src_pixel[7:0] > r_thresh) ? i_draw_color
                                                                : i_dst_pixel;
                end
                default: o_cmd.value = i_dst_pixel;
            endcase
        end
    end

    always_comb begin
        n_left   = r_left;
        n_right  = r_right;
        n_top    = r_top;
        n_bottom = r_bottom;
        if (i_accept) begin
            if (i_op == pcdr_pkg::OP_FLUSH) begin
                n_left   = W_C;
                n_right  = '0;
                n_top    = H_C;
                n_bottom = '0;
            end else if (on_screen) begin
                if (r_left > ux)    n_left   = ux;
                if (r_top > uy)     n_top    = uy;
                if (r_right < ux1)  n_right  = ux1;
                if (r_bottom < uy1) n_bottom = uy1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= pcdr_pkg::THRESH_RESET;
            r_left   <= W_C;
            r_right  <= '0;
            r_top    <= H_C;
            r_bottom <= '0;
        end else begin
            if (i_cfg_valid) r_thresh <= i_cfg_data;
            r_left   <= n_left;
            r_right  <= n_right;
            r_top    <= n_top;
            r_bottom <= n_bottom;
        end
    end

endmodule

[hdl/pcdr_fifo.sv]
// ----------------------------------------------------------------------------
// pcdr_fifo
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module pcdr_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  pcdr_pkg::t_cmd i_wdata,
    output logic           o_full,
    input  logic           i_rd,
    output pcdr_pkg::t_cmd o_rdata,
    output logic           o_empty
);

    pcdr_pkg::t_cmd r_mem [pcdr_pkg::QUEUE_DEPTH];
    logic [pcdr_pkg::QPTR_W-1:0] r_wptr, r_rptr;
    logic [pcdr_pkg::QCNT_W-1:0] r_count;

    assign o_full  = (r_count == pcdr_pkg::QCNT_W'(pcdr_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_wr) r_mem[r_wptr] <= i_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_wr) r_wptr <= r_wptr + 1'b1;
            if (i_rd) r_rptr <= r_rptr + 1'b1;
            unique case ({i_wr, i_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[hdl/pcdr_back.sv]
// ----------------------------------------------------------------------------
// pcdr_back
// Runs the per-channel alpha blend and holds the result register.
// ----------------------------------------------------------------------------
module pcdr_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_q_empty,
    input  pcdr_pkg::t_cmd                       i_cmd,
    output logic                                 o_q_rd,
    input  logic                                 i_pop,
    output logic                                 o_empty,
    output logic                                 o_write_en,
    output logic [pcdr_pkg::ADDR_W-1:0]          o_pixel_addr,
    output logic [pcdr_pkg::PIX_W-1:0]           o_pixel_value,
    output logic                                 o_area_valid,
    output logic [pcdr_pkg::COORD_W-1:0]         o_area_left,
    output logic [pcdr_pkg::COORD_W-1:0]         o_area_right,
    output logic [pcdr_pkg::COORD_W-1:0]         o_area_top,
    output logic [pcdr_pkg::COORD_W-1:0]         o_area_bottom
);

    logic                         r_valid;
    pcdr_pkg::t_cmd               r_res;
    pcdr_pkg::t_cmd               n_res;
    logic [pcdr_pkg::PIX_W-1:0]   blended;
    logic [7:0]                   a;

    assign a = i_cmd.value[31:24];
    assign blended = pcdr_pkg::ALPHA_FORCE |
        {8'h00,
         pcdr_pkg::mix_channel(a, i_cmd.value[23:16], i_cmd.dst[23:16]),
         pcdr_pkg::mix_channel(a, i_cmd.value[15:8],  i_cmd.dst[15:8]),
         pcdr_pkg::mix_channel(a, i_cmd.value[7:0],   i_cmd.dst[7:0])};

    // Load whenever the queue holds a command and the slot is free or being drained this cycle.
    assign o_q_rd = !i_q_empty && (!r_valid || i_pop);

    always_comb begin
        n_res       = i_cmd;
        n_res.value = i_cmd.do_blend ? blended : i_cmd.value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_rd) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_res <= n_res;
        end
    end

    assign o_empty       = !r_valid;
    assign o_write_en    = r_res.write_en;
    assign o_pixel_addr  = r_res.pixel_addr;
    assign o_pixel_value = r_res.value;
    assign o_area_valid  = r_res.area_valid;
    assign o_area_left   = r_res.area_left;
    assign o_area_right  = r_res.area_right;
    assign o_area_top    = r_res.area_top;
    assign o_area_bottom = r_res.area_bottom;

endmodule

[hdl/pcdr_checker.sv]
// ----------------------------------------------------------------------------
// pcdr_checker
// Port-level checks for the compositor core, bound to the top level.
// ----------------------------------------------------------------------------
module pcdr_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         full,
    input  logic                         empty,
    input  logic                         pop,
    input  logic                         o_write_en,
    input  logic [pcdr_pkg::ADDR_W-1:0]  o_pixel_addr,
    input  logic [pcdr_pkg::PIX_W-1:0]   o_pixel_value,
    input  logic                         o_area_valid,
    input  logic [pcdr_pkg::COORD_W-1:0] o_area_left,
    input  logic [pcdr_pkg::COORD_W-1:0] o_area_right,
    input  logic [pcdr_pkg::COORD_W-1:0] o_area_top,
    input  logic [pcdr_pkg::COORD_W-1:0] o_area_bottom
);

    // reset drains both sides
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queue not drained by reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_pixel_value) &&
                              $stable(o_pixel_addr)))
        else $error("held result changed");

    a_kind_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> !(o_write_en && o_area_valid))
        else $error("result is both a pixel write and an area report");

    a_area_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_area_valid) |->
            ((o_area_right > o_area_left) && (o_area_bottom > o_area_top)))
        else $error("reported area is empty");

    a_nowrite_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_write_en) |-> ((o_pixel_addr == '0) && (o_pixel_value == '0)))
        else $error("non-write result carries pixel data");

endmodule

bind pixel_compositor_dirty_rect_core pcdr_checker u_pcdr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .o_write_en    (o_write_en),
    .o_pixel_addr  (o_pixel_addr),
    .o_pixel_value (o_pixel_value),
    .o_area_valid  (o_area_valid),
    .o_area_left   (o_area_left),
    .o_area_right  (o_area_right),
    .o_area_top    (o_area_top),
    .o_area_bottom (o_area_bottom)
);
